// ===== rtl/key_value_command_line_parser_unit_defines.svh =====
// Assertion macros for the command line parser top level.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef KEY_VALUE_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH
`define KEY_VALUE_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KVCLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kvclp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KVCLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kvclp: next-cycle check failed");

`endif

// ===== rtl/kvclp_pkg.sv =====
// Types, constants and token helpers for the command line parser.
// No dependencies; used by kvclp_parse and the top level.
package kvclp_pkg;

    localparam int LINE_BUFFER_BYTES = 128;
    localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BUFFER_BYTES - 1);

    localparam logic [7:0] TERM_RESET = 8'd10;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_L     = 8'h4C;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_BAR   = 8'h7C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [15:0] MAG_MAX   = 16'hFFFF;
    localparam logic [2:0]  DIR_MAX   = 3'd4;
    localparam logic [7:0]  SPEED_MAX = 8'd255;

    localparam int PADDR_W = 3;
    localparam logic IDX_TERMINATOR = 1'b0;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_KEY,
        PH_VAL_WS,
        PH_VAL_DIG,
        PH_VAL_DONE
    } phase_t;

    typedef struct packed {
        logic        lights;
        logic        buzzer;
        logic [7:0]  speed;
        logic [2:0]  dir;
    } cmd_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  key1;
        logic [7:0]  key2;
        logic [1:0]  kcount;
        logic        neg;
        logic [15:0] mag;
    } token_t;

    typedef struct packed {
        cmd_t pend;
        logic any;
    } line_t;

    localparam token_t TOKEN_IDLE = '{PH_SKIP, 8'd0, 8'd0, 2'd0, 1'b0, 16'd0};
    localparam line_t  LINE_IDLE  = '{cmd_t'('0), 1'b0};

    // Apply the open token's key and value to the pending command.
    function automatic line_t finish_token(token_t tok, line_t ln);
        line_t r;
        logic  zero;
        r    = ln;
        zero = (tok.mag == 16'd0);
        if (tok.phase == PH_VAL_WS || tok.phase == PH_VAL_DIG || tok.phase == PH_VAL_DONE) begin
            if (tok.kcount == 2'd1 && tok.key1 == CHAR_D) begin
                if (zero || (!tok.neg && tok.mag <= 16'(DIR_MAX)))
                    r.pend.dir = tok.mag[2:0];
                r.any = 1'b1;
            end else if (tok.kcount == 2'd1 && tok.key1 == CHAR_P) begin
                if (tok.neg || zero)
                    r.pend.speed = 8'd0;
                else if (tok.mag > 16'(SPEED_MAX))
                    r.pend.speed = SPEED_MAX;
                else
                    r.pend.speed = tok.mag[7:0];
                r.any = 1'b1;
            end else if (tok.kcount == 2'd2 && tok.key1 == CHAR_B && tok.key2 == CHAR_Z) begin
                r.pend.buzzer = !zero;
                r.any = 1'b1;
            end else if (tok.kcount == 2'd2 && tok.key1 == CHAR_L && tok.key2 == CHAR_T) begin
                r.pend.lights = !zero;
                r.any = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic is_white(logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

// ===== rtl/kvclp_parse.sv =====
// Line and token state of the parser with its one-byte update.
// Depends on kvclp_pkg.
module kvclp_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           in_byte,
    input  logic [7:0]           terminator,
    output logic                 res_valid,
    output kvclp_pkg::cmd_t      res_cmd
);

    logic [kvclp_pkg::LEN_W-1:0] len_reg, len_next;
    logic                        ended_reg, ended_next;
    kvclp_pkg::token_t           tok_reg, tok_next;
    kvclp_pkg::line_t            line_reg, line_next;

    always_comb begin
        kvclp_pkg::line_t  fin;
        kvclp_pkg::line_t  at_end;
        logic [19:0]       prod;
        fin       = kvclp_pkg::finish_token(tok_reg, line_reg);
        at_end    = ended_reg ? line_reg : fin;
        prod      = ({4'd0, tok_reg.mag} << 3) + ({4'd0, tok_reg.mag} << 1)
                  + {12'd0, in_byte - kvclp_pkg::CHAR_ZERO};
        len_next  = len_reg;
        ended_next = ended_reg;
        tok_next  = tok_reg;
        line_next = line_reg;
        res_valid = 1'b0;
        res_cmd   = at_end.pend;
        if (in_byte == terminator) begin
            res_valid  = (len_reg != '0) && at_end.any;
            len_next   = '0;
            ended_next = 1'b0;
            tok_next   = kvclp_pkg::TOKEN_IDLE;
            line_next  = kvclp_pkg::LINE_IDLE;
        end else if (len_reg >= kvclp_pkg::LEN_MAX) begin
            // overlong line: drop everything and restart
            len_next   = '0;
            ended_next = 1'b0;
            tok_next   = kvclp_pkg::TOKEN_IDLE;
            line_next  = kvclp_pkg::LINE_IDLE;
        end else begin
            len_next = len_reg + 1'b1;
            if (ended_reg) begin
                // content is over, only count
            end else if (in_byte == kvclp_pkg::CHAR_NUL) begin
                line_next  = fin;
                tok_next   = kvclp_pkg::TOKEN_IDLE;
                ended_next = 1'b1;
            end else if (in_byte == kvclp_pkg::CHAR_BAR) begin
                line_next = fin;
                tok_next  = kvclp_pkg::TOKEN_IDLE;
            end else begin
                case (tok_reg.phase)
                    kvclp_pkg::PH_SKIP: begin
                        if (in_byte == kvclp_pkg::CHAR_COLON) begin
                            tok_next.phase = kvclp_pkg::PH_VAL_WS;
                        end else if (in_byte != kvclp_pkg::CHAR_SPACE) begin
                            tok_next.key1   = in_byte;
                            tok_next.kcount = 2'd1;
                            tok_next.phase  = kvclp_pkg::PH_KEY;
                        end
                    end
                    kvclp_pkg::PH_KEY: begin
                        if (in_byte == kvclp_pkg::CHAR_COLON) begin
                            tok_next.phase = kvclp_pkg::PH_VAL_WS;
                        end else begin
                            if (tok_reg.kcount == 2'd1)
                                tok_next.key2 = in_byte;
                            if (tok_reg.kcount != 2'd3)
                                tok_next.kcount = tok_reg.kcount + 2'd1;
                        end
                    end
                    kvclp_pkg::PH_VAL_WS, kvclp_pkg::PH_VAL_DIG: begin
                        if (tok_reg.phase == kvclp_pkg::PH_VAL_WS && kvclp_pkg::is_white(in_byte)) begin
                            // skip white space before the value
                        end else if (tok_reg.phase == kvclp_pkg::PH_VAL_WS &&
                                     (in_byte == kvclp_pkg::CHAR_PLUS ||
                                      in_byte == kvclp_pkg::CHAR_MINUS)) begin
                            tok_next.neg   = (in_byte == kvclp_pkg::CHAR_MINUS);
                            tok_next.phase = kvclp_pkg::PH_VAL_DIG;
                        end else if (kvclp_pkg::is_digit(in_byte)) begin
                            tok_next.phase = kvclp_pkg::PH_VAL_DIG;
                            tok_next.mag   = (prod > {4'd0, kvclp_pkg::MAG_MAX}) ?
                                             kvclp_pkg::MAG_MAX : prod[15:0];
                        end else begin
                            tok_next.phase = kvclp_pkg::PH_VAL_DONE;
                        end
                    end
                    default: begin
                        // value done: ignore until the token ends
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            ended_reg <= 1'b0;
            tok_reg   <= kvclp_pkg::TOKEN_IDLE;
            line_reg  <= kvclp_pkg::LINE_IDLE;
        end else if (step_en) begin
            len_reg   <= len_next;
            ended_reg <= ended_next;
            tok_reg   <= tok_next;
            line_reg  <= line_next;
        end
    end

endmodule

// ===== rtl/key_value_command_line_parser_unit.sv =====
// Key/value command line parser, top level.
// Slave stream: one received byte per item in s_tdata. Master stream: one
// command per recognised line. Configuration: APB port holding the line
// terminator byte (register 0, byte address 0, reset 10).
// A command enters the output register (m_tdata) when its terminator byte is
// taken from the input register and the output register is free.
// Throughput: one byte per cycle unless the output stalls; the only per-byte
// loop is the parse state update, combinational between the two registers.
// A line gives a command only if it held at least one byte and a known key
// (D, P, BZ, LT); every line starts from direction 0, speed 0, flags off.
// When m_tready is low the command is held; the input register still takes
// one more byte, then s_tready drops until the command is taken.
// Reset (aresetn low, synchronous) empties both registers, restores the
// terminator to 10 and clears the parse state. No clearing pass is needed.
// Depends on kvclp_pkg, kvclp_parse and the defines header.
`include "key_value_command_line_parser_unit_defines.svh"

module key_value_command_line_parser_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] in_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] command_direction, [10:3] command_speed, [11] command_buzzer,
    // [12] command_lights, [15:13] zero
    output logic [15:0]                    m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kvclp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             m_valid_reg, m_valid_next;
    kvclp_pkg::cmd_t  cmd_reg;
    logic [7:0]       term_reg, term_next;
    logic             consume;
    logic             res_valid;
    kvclp_pkg::cmd_t  res_cmd;
    logic             cfg_write;

    assign consume   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || consume;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {3'd0, cmd_reg};
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[kvclp_pkg::PADDR_W-1] == kvclp_pkg::IDX_TERMINATOR);
    assign prdata    = (paddr[kvclp_pkg::PADDR_W-1] == kvclp_pkg::IDX_TERMINATOR) ?
                       {24'd0, term_reg} : 32'd0;

    kvclp_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (consume),
        .in_byte    (in_byte_reg),
        .terminator (term_reg),
        .res_valid  (res_valid),
        .res_cmd    (res_cmd)
    );

    always_comb begin
        in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !consume);
        if (consume && res_valid)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
        term_next = cfg_write ? pwdata[7:0] : term_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            term_reg     <= kvclp_pkg::TERM_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            term_reg     <= term_next;
        end
    end

    // payload: hold unless a new item or command is loaded
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (consume && res_valid)
            cmd_reg <= res_cmd;
    end

    `KVCLP_ASSERT_NOW(a_ready_only_when_room, !s_tready, in_valid_reg && m_valid_reg && !m_tready)
    `KVCLP_ASSERT_NEXT(a_stalled_byte_kept, in_valid_reg && !consume, in_valid_reg && $stable(in_byte_reg))
    `KVCLP_ASSERT_NOW(a_direction_in_range, m_tvalid, m_tdata[2:0] <= kvclp_pkg::DIR_MAX)
    `KVCLP_ASSERT_NEXT(a_command_from_step, consume && res_valid, m_tvalid)

endmodule

// ===== bench/key_value_command_line_parser_unit_tb.sv =====
// Self-checking bench for key_value_command_line_parser_unit: byte stream in, commands out.
// Needs kvclp_pkg and the top level. Every accepted byte is run through a local
// line parser, and each command that leaves the block is compared with the oldest expected command.
`timescale 1ns / 100ps

module key_value_command_line_parser_unit_tb;
    import kvclp_pkg::*;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PHASES      = 6;
    localparam int          PHASE_BYTES = 320;
    localparam int          PLAN_ROWS   = 33;
    localparam logic [PADDR_W-1:0] TERM_ADDR = PADDR_W'(4 * IDX_TERMINATOR);
    localparam cmd_t        NO_CMD      = '0;
    localparam logic [7:0]  KEY_CHARS [7] = '{CHAR_D, CHAR_P, CHAR_B, CHAR_Z, CHAR_L, CHAR_T, 8'h58};

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_SILENT,
        ROW_CMD
    } row_kind_t;

    typedef struct {
        logic [7:0] data;
        row_kind_t  kind;
        cmd_t       cmd;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // [7:0] in_byte
    logic                m_tvalid;
    logic                m_tready;
    // [2:0] command_direction, [10:3] command_speed, [11] command_buzzer,
    // [12] command_lights, [15:13] zero
    logic [15:0]         m_tdata;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Line parser state, mirrors the block
    logic [7:0]          term_byte;
    logic [LEN_W-1:0]    run_len;
    bit                  line_cut;
    phase_t              tok_phase;
    logic [7:0]          key_a;
    logic [7:0]          key_b;
    logic [1:0]          key_n;
    bit                  val_neg;
    logic [15:0]         val_mag;
    cmd_t                pend_cmd;
    bit                  key_seen;

    cmd_t                cmd_q [$];
    logic [7:0]          line_q [$];
    int                  max_gap;
    bit                  hold_req;
    int                  hold_count;
    int unsigned         cycle_count;
    int                  bytes_sent;
    int                  lines_sent;
    int                  cmds_checked;
    int                  err_count;

    // Directed lines under the reset terminator
    stim_row_t plan [PLAN_ROWS] = '{
        '{TERM_RESET, ROW_SILENT, NO_CMD},
        '{"D", ROW_PREDICT, NO_CMD}, '{":", ROW_PREDICT, NO_CMD}, '{"4", ROW_PREDICT, NO_CMD},
        '{"|", ROW_PREDICT, NO_CMD}, '{"D", ROW_PREDICT, NO_CMD}, '{":", ROW_PREDICT, NO_CMD},
        '{"9", ROW_PREDICT, NO_CMD}, '{"|", ROW_PREDICT, NO_CMD}, '{"P", ROW_PREDICT, NO_CMD},
        '{":", ROW_PREDICT, NO_CMD}, '{"9", ROW_PREDICT, NO_CMD}, '{"9", ROW_PREDICT, NO_CMD},
        '{"9", ROW_PREDICT, NO_CMD},
        '{TERM_RESET, ROW_CMD, '{lights: 1'b0, buzzer: 1'b0, speed: 8'd255, dir: 3'd4}},
        '{" ", ROW_PREDICT, NO_CMD}, '{"B", ROW_PREDICT, NO_CMD}, '{"Z", ROW_PREDICT, NO_CMD},
        '{":", ROW_PREDICT, NO_CMD}, '{"1", ROW_PREDICT, NO_CMD}, '{"|", ROW_PREDICT, NO_CMD},
        '{"L", ROW_PREDICT, NO_CMD}, '{"T", ROW_PREDICT, NO_CMD}, '{":", ROW_PREDICT, NO_CMD},
        '{"-", ROW_PREDICT, NO_CMD}, '{"2", ROW_PREDICT, NO_CMD},
        '{TERM_RESET, ROW_CMD, '{lights: 1'b1, buzzer: 1'b1, speed: 8'd0, dir: 3'd0}},
        '{8'hFF, ROW_PREDICT, NO_CMD}, '{CHAR_NUL, ROW_PREDICT, NO_CMD},
        '{"D", ROW_PREDICT, NO_CMD}, '{":", ROW_PREDICT, NO_CMD}, '{"3", ROW_PREDICT, NO_CMD},
        '{TERM_RESET, ROW_SILENT, NO_CMD}
    };

    key_value_command_line_parser_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles", $time, cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- line parser

    function automatic void clear_token();
        tok_phase = PH_SKIP;
        key_a     = 8'd0;
        key_b     = 8'd0;
        key_n     = 2'd0;
        val_neg   = 1'b0;
        val_mag   = 16'd0;
    endfunction

    function automatic void clear_line();
        run_len  = '0;
        line_cut = 1'b0;
        pend_cmd = '0;
        key_seen = 1'b0;
        clear_token();
    endfunction

    // Apply the open key/value pair to the pending command.
    function automatic void close_token();
        bit nil;
        nil = (val_mag == 16'd0);
        if (tok_phase == PH_VAL_WS || tok_phase == PH_VAL_DIG || tok_phase == PH_VAL_DONE) begin
            if (key_n == 2'd1 && key_a == CHAR_D) begin
                if (nil || (!val_neg && val_mag <= 16'(DIR_MAX)))
                    pend_cmd.dir = val_mag[2:0];
                key_seen = 1'b1;
            end else if (key_n == 2'd1 && key_a == CHAR_P) begin
                if (val_neg || nil)
                    pend_cmd.speed = 8'd0;
                else
                    pend_cmd.speed = (val_mag > 16'(SPEED_MAX)) ? SPEED_MAX : val_mag[7:0];
                key_seen = 1'b1;
            end else if (key_n == 2'd2 && key_a == CHAR_B && key_b == CHAR_Z) begin
                pend_cmd.buzzer = !nil;
                key_seen = 1'b1;
            end else if (key_n == 2'd2 && key_a == CHAR_L && key_b == CHAR_T) begin
                pend_cmd.lights = !nil;
                key_seen = 1'b1;
            end
        end
        clear_token();
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic void digest_char(input logic [7:0] c);
        logic [19:0] m;
        if (c == CHAR_BAR) begin
            close_token();
            return;
        end
        case (tok_phase)
            PH_SKIP: begin
                if (c == CHAR_COLON) begin
                    tok_phase = PH_VAL_WS;
                end else if (c != CHAR_SPACE) begin
                    key_a     = c;
                    key_n     = 2'd1;
                    tok_phase = PH_KEY;
                end
            end
            PH_KEY: begin
                if (c == CHAR_COLON) begin
                    tok_phase = PH_VAL_WS;
                end else begin
                    if (key_n == 2'd1)
                        key_b = c;
                    if (key_n < 2'd3)
                        key_n = key_n + 2'd1;
                end
            end
            PH_VAL_WS, PH_VAL_DIG: begin
                if (tok_phase == PH_VAL_WS) begin
                    if (is_blank(c))
                        return;
                    tok_phase = PH_VAL_DIG;
                    if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        val_neg = (c == CHAR_MINUS);
                        return;
                    end
                end
                if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                    m       = 20'(val_mag) * 20'd10 + 20'(c - CHAR_ZERO);
                    val_mag = (m > 20'(MAG_MAX)) ? MAG_MAX : m[15:0];
                end else begin
                    tok_phase = PH_VAL_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    // Advance the parser by one accepted byte; made is set when the byte emits a command.
    function automatic void predict_byte(input logic [7:0] c, output bit made, output cmd_t res);
        made = 1'b0;
        res  = '0;
        if (c == term_byte) begin
            if (!line_cut)
                close_token();
            if (run_len != '0 && key_seen) begin
                made = 1'b1;
                res  = pend_cmd;
            end
            clear_line();
            return;
        end
        // overlong line: drop the byte and discard everything so far
        if (run_len >= LEN_MAX) begin
            clear_line();
            return;
        end
        run_len = run_len + 1'b1;
        if (line_cut)
            return;
        if (c == CHAR_NUL) begin
            close_token();
            line_cut = 1'b1;
            return;
        end
        digest_char(c);
    endfunction

    // ---------------------------------------------------------------- result side

    function automatic void check_cmd(input logic [15:0] word);
        cmd_t want;
        cmd_t seen;
        seen = cmd_t'(word[12:0]);
        cmds_checked++;
        if (cmd_q.size() == 0) begin
            $display("%0t: expected no command, got dir %0d speed %0d buzzer %0d lights %0d",
                     $time, seen.dir, seen.speed, seen.buzzer, seen.lights);
            err_count++;
            return;
        end
        want = cmd_q.pop_front();
        if (seen.dir !== want.dir) begin
            $display("%0t: direction expected %0d got %0d", $time, want.dir, seen.dir);
            err_count++;
        end
        if (seen.speed !== want.speed) begin
            $display("%0t: speed expected %0d got %0d", $time, want.speed, seen.speed);
            err_count++;
        end
        if (seen.buzzer !== want.buzzer) begin
            $display("%0t: buzzer expected %0d got %0d", $time, want.buzzer, seen.buzzer);
            err_count++;
        end
        if (seen.lights !== want.lights) begin
            $display("%0t: lights expected %0d got %0d", $time, want.lights, seen.lights);
            err_count++;
        end
        if (word[15:13] !== 3'd0) begin
            $display("%0t: pad bits expected 0 got %b", $time, word[15:13]);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_cmd(m_tdata);
    end

    initial begin : drain_side
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            // long hold-off, once: let the block back up into its input
            if (hold_req && hold_count == 0) begin
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge aclk);
                hold_count++;
            end
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready))
                @(posedge aclk);
        end
    end

    // ---------------------------------------------------------------- input side

    task automatic offer_byte(input logic [7:0] b, input row_kind_t kind, input cmd_t typed);
        int   gap;
        bit   made;
        cmd_t res;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_byte(b, made, res);
        bytes_sent++;
        case (kind)
            ROW_PREDICT: if (made) cmd_q.push_back(res);
            ROW_CMD:     cmd_q.push_back(typed);
            default:     ;
        endcase
    endtask

    task automatic settle();
        while (cmd_q.size() != 0)
            @(posedge aclk);
        // bytes that give no command may still sit in the pipeline
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write_term(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TERM_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        term_byte = value;
    endtask

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? CHAR_SPACE : 8'($urandom_range(CHAR_TAB, CHAR_CR));
    endfunction

    function automatic void add_value(input bit short_val);
        int n;
        if ($urandom_range(0, 3) == 0)
            line_q.push_back(pick_blank());
        case ($urandom_range(0, 5))
            0:       line_q.push_back(CHAR_PLUS);
            1:       line_q.push_back(CHAR_MINUS);
            default: ;
        endcase
        n = short_val ? $urandom_range(0, 2) : $urandom_range(0, 6);
        repeat (n) line_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0)
            line_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_token();
        int n;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) line_q.push_back(CHAR_SPACE);
        case ($urandom_range(0, 9))
            0, 1: begin
                line_q.push_back(CHAR_D);
                line_q.push_back(CHAR_COLON);
                add_value(1'b1);
            end
            2, 3: begin
                line_q.push_back(CHAR_P);
                line_q.push_back(CHAR_COLON);
                add_value(1'b0);
            end
            4: begin
                line_q.push_back(CHAR_B);
                line_q.push_back(CHAR_Z);
                line_q.push_back(CHAR_COLON);
                add_value(1'b0);
            end
            5: begin
                line_q.push_back(CHAR_L);
                line_q.push_back(CHAR_T);
                line_q.push_back(CHAR_COLON);
                add_value(1'b0);
            end
            6: begin
                // near-miss keys, including none at all before the colon
                n = $urandom_range(0, 4);
                repeat (n) line_q.push_back(KEY_CHARS[$urandom_range(0, 6)]);
                line_q.push_back(CHAR_COLON);
                add_value(1'b0);
            end
            7: ;
            8: begin
                line_q.push_back(CHAR_B);
                line_q.push_back(CHAR_Z);
                add_value(1'b1);
            end
            default: begin
                repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endfunction

    function automatic void build_line(input bit overlong);
        int r;
        line_q.delete();
        if (overlong)
            repeat ($urandom_range(118, 135))
                line_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_BAR);
        r = $urandom_range(0, 99);
        if (r < 10) begin
            repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
        end else if (r >= 13) begin
            for (int t = $urandom_range(1, 4); t > 0; t--) begin
                add_token();
                if (t > 1)
                    line_q.push_back(CHAR_BAR);
            end
            if (r < 18) begin
                line_q.push_back(CHAR_NUL);
                repeat ($urandom_range(0, 3)) line_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        line_q.push_back(term_byte);
    endfunction

    initial begin : stimulus
        logic [7:0] terms [PHASES];
        int         goal;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= 32'd0;
        aresetn  <= 1'b0;
        hold_req    = 1'b0;
        max_gap     = 4;
        term_byte   = TERM_RESET;
        clear_line();
        terms = '{8'h00, 8'hFF, TERM_RESET, 8'h3B, CHAR_CR, 8'($urandom_range(0, 255))};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_ROWS; i++)
            offer_byte(plan[i].data, plan[i].kind, plan[i].cmd);
        s_tvalid <= 1'b0;
        settle();

        for (int p = 0; p < PHASES; p++) begin
            apb_write_term(terms[p]);
            max_gap = (p == 2) ? 0 : 4;
            if (p == 1)
                hold_req = 1'b1;
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal) begin
                build_line((p == 0 || p == 3) && bytes_sent + PHASE_BYTES == goal);
                lines_sent++;
                foreach (line_q[i])
                    offer_byte(line_q[i], ROW_PREDICT, NO_CMD);
            end
            s_tvalid <= 1'b0;
            settle();
        end

        repeat (10) @(posedge aclk);
        $display("Covered %0d bytes in %0d random lines over %0d terminator settings.",
                 bytes_sent, lines_sent, PHASES + 1);
        $display("Compared %0d commands; output held off %0d time(s) for %0d cycles.",
                 cmds_checked, hold_count, HOLD_CYCLES);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
